@@ src/cack_pkg.sv @@
// ----------------------------------------------------------------------------
// cack_pkg
// Shared types and constants for the cumulative-ack receiver.
// ----------------------------------------------------------------------------
package cack_pkg;

    localparam int SEQ_SPACE_DEF = 65536;
    localparam int SEQ_W         = 16;
    localparam int MODE_W        = 4;
    localparam int ACK_W         = 17;
    localparam int QUEUE_DEPTH   = 2;

    localparam int MODE_SYN_BIT  = 0;
    localparam int MODE_FIN_BIT  = 2;

    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 24;

    typedef enum logic [1:0] {
        REPLY_ACK    = 2'd0,
        REPLY_RESEND = 2'd1,
        REPLY_FIN    = 2'd2
    } reply_kind_t;

    typedef struct packed {
        reply_kind_t        kind;
        logic [SEQ_W-1:0]   seq;
        logic               in_range;
        logic               store_payload;
        logic               header_packet;
    } cmd_t;

    typedef struct packed {
        reply_kind_t               reply_kind;
        logic signed [ACK_W-1:0]   ack_number;
        logic                      duplicate_ack;
        logic                      store_payload;
        logic                      header_packet;
    } result_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

@@ src/cack_ram.sv @@
// ----------------------------------------------------------------------------
// cack_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cack_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/cack_queue.sv @@
// ----------------------------------------------------------------------------
// cack_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module cack_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  cack_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output cack_pkg::cmd_t          head,
    output cack_pkg::queue_status_t status
);
    import cack_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.valid = count_reg != '0;
    assign status.full  = count_reg == CNT_W'(QUEUE_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + IDX_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + IDX_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

@@ src/cack_front.sv @@
// ----------------------------------------------------------------------------
// cack_front
// Accept packet headers, classify them and hand commands to the queue.
// ----------------------------------------------------------------------------
module cack_front #(
    parameter int SEQ_SPACE = cack_pkg::SEQ_SPACE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cack_pkg::MODE_W-1:0]   mode,
    input  logic [cack_pkg::SEQ_W-1:0]    seq_number,
    input  logic                          checksum_ok,
    input  logic                          clearing,
    input  cack_pkg::queue_status_t       q_status,
    output logic                          push,
    output cack_pkg::cmd_t                push_cmd
);
    import cack_pkg::*;

    logic closed_reg, closed_next;
    logic data_pkt;
    logic in_range;

    assign data_pkt = mode[MODE_SYN_BIT] && !mode[MODE_FIN_BIT];
    assign in_range = {1'b0, seq_number} < (SEQ_W + 1)'(SEQ_SPACE);

    assign s_tready = !clearing && (closed_reg || !q_status.full);
    assign push     = s_tvalid && s_tready && !closed_reg;

    always_comb
    begin
        push_cmd.seq           = seq_number;
        push_cmd.in_range      = in_range;
        push_cmd.store_payload = in_range && (seq_number != '0);
        push_cmd.header_packet = in_range && (seq_number == '0);
        if (!data_pkt)
        begin
            push_cmd.kind = REPLY_FIN;
        end
        else if (checksum_ok)
        begin
            push_cmd.kind = REPLY_ACK;
        end
        else
        begin
            push_cmd.kind = REPLY_RESEND;
        end

        closed_next = closed_reg;
        if (push && push_cmd.kind == REPLY_FIN)
        begin
            closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b0;
        end
        else
        begin
            closed_reg <= closed_next;
        end
    end

`ifndef SYNTH
    a_closed_drops: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> !push)
        else $error("command pushed after close");
`endif

endmodule

@@ src/cack_back.sv @@
// ----------------------------------------------------------------------------
// cack_back
// Execute queued commands: mark the bitmap, walk the cumulative pointer, reply.
// ----------------------------------------------------------------------------
module cack_back #(
    parameter int SEQ_SPACE = cack_pkg::SEQ_SPACE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cack_pkg::queue_status_t q_status,
    input  cack_pkg::cmd_t          head,
    output logic                    pop,
    output logic                    clearing,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output cack_pkg::result_t       result
);
    import cack_pkg::*;

    localparam int ADDR_W = $clog2(SEQ_SPACE);
    localparam int PTR_W  = $clog2(SEQ_SPACE + 1);

    typedef enum logic [3:0] {
        ST_CLEAR    = 4'b0001,
        ST_IDLE     = 4'b0010,
        ST_SCAN_RD  = 4'b0100,
        ST_SCAN_CHK = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  before_reg, before_next;
    cmd_t              cmd_reg, cmd_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic              ram_rdata;
    logic              finish;
    logic [ACK_W-1:0]  ack_value;

    cack_ram #(
        .WIDTH (1),
        .DEPTH (SEQ_SPACE)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign clearing  = state_reg == ST_CLEAR;
    assign m_tvalid  = out_valid_reg;
    assign result    = out_reg;
    assign ack_value = ACK_W'(ptr_reg) - ACK_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ptr_next       = ptr_reg;
        before_next    = before_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_cnt_reg;
        ram_wdata      = 1'b0;
        pop            = 1'b0;
        finish         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(SEQ_SPACE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_status.valid && !out_valid_reg)
                begin
                    pop = 1'b1;
                    out_next.duplicate_ack = 1'b0;
                    out_next.store_payload = 1'b0;
                    out_next.header_packet = 1'b0;
                    case (head.kind)
                        REPLY_ACK:
                        begin
                            if (head.in_range)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = head.seq[ADDR_W-1:0];
                                ram_wdata   = 1'b1;
                                before_next = ptr_reg;
                                cmd_next    = head;
                                state_next  = ST_SCAN_RD;
                            end
                            else
                            begin
                                out_valid_next         = 1'b1;
                                out_next.reply_kind    = REPLY_ACK;
                                out_next.ack_number    = $signed(ack_value);
                                out_next.duplicate_ack = 1'b1;
                            end
                        end
                        REPLY_RESEND:
                        begin
                            out_valid_next      = 1'b1;
                            out_next.reply_kind = REPLY_RESEND;
                            out_next.ack_number = $signed({1'b0, head.seq});
                        end
                        default:
                        begin
                            out_valid_next      = 1'b1;
                            out_next.reply_kind = REPLY_FIN;
                            out_next.ack_number = '0;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                if (ptr_reg == PTR_W'(SEQ_SPACE))
                begin
                    finish = 1'b1;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (ram_rdata)
                begin
                    ptr_next   = ptr_reg + PTR_W'(1);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next             = ST_IDLE;
            out_valid_next         = 1'b1;
            out_next.reply_kind    = REPLY_ACK;
            out_next.ack_number    = $signed(ack_value);
            out_next.duplicate_ack = ptr_reg == before_reg;
            out_next.store_payload = cmd_reg.store_payload;
            out_next.header_packet = cmd_reg.header_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        before_reg <= before_next;
        cmd_reg    <= cmd_next;
        out_reg    <= out_next;
    end

`ifndef SYNTH
    a_ptr_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg >= $past(ptr_reg))
        else $error("cumulative pointer moved backwards");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(SEQ_SPACE))
        else $error("cumulative pointer beyond sequence space");

    a_no_reply_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!out_valid_reg && !pop))
        else $error("activity during clearing pass");

    a_scan_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CHK && !ram_rdata) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("scan did not stop on an unreceived entry");
`endif

endmodule

@@ src/cumulative_ack_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// cumulative_ack_receiver_unit
// Receiver side of a reliable transfer with a cumulative acknowledgement.
//
// Slave channel: one packet header per transaction (flags in s_tuser, sequence
// number and checksum result in s_tdata). Master channel: one reply per
// header until a closing packet; later headers are taken and dropped.
// After reset the received bitmap is swept to zero, one entry per cycle;
// s_tready stays low during that sweep.
// Headers are classified on entry and wait in a two-entry command queue, so
// the slave side keeps accepting while a reply is held by a stalled receiver,
// until the queue fills and s_tready drops.
// A resend request or closing reply is queued on acceptance; m_tvalid rises
// from the output register once the back end pops it. A cumulative ACK marks
// the bitmap, then walks the pointer, a read and a check state per entry as
// the RAM reads through a register, to an unreceived entry or the space end.
// The next command starts the cycle after the held reply is taken.
// ----------------------------------------------------------------------------
module cumulative_ack_receiver_unit #(
    parameter int SEQ_SPACE = cack_pkg::SEQ_SPACE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cack_pkg::S_TDATA_W-1:0]   s_tdata,  // seq_number, checksum_ok
    input  logic [cack_pkg::MODE_W-1:0]      s_tuser,  // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // ack_number, duplicate_ack, store_payload, header_packet
    output logic [cack_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser   // reply_kind
);
    import cack_pkg::*;

    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head;
    queue_status_t q_status;
    logic          clearing;
    result_t       result;

    cack_front #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .mode        (s_tuser),
        .seq_number  (s_tdata[SEQ_W-1:0]),
        .checksum_ok (s_tdata[SEQ_W]),
        .clearing    (clearing),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    cack_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    cack_back #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tuser = result.reply_kind;
    assign m_tdata = {
        (M_TDATA_W - ACK_W - 3)'(0),
        result.header_packet,
        result.store_payload,
        result.duplicate_ack,
        result.ack_number
    };

endmodule

@@ tb/sv/tb_cumulative_ack_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cumulative_ack_receiver_unit
// Self-checking bench for the cumulative-ack receiver. Packet headers go in on
// the slave stream, and replies are predicted from a bitmap and pointer kept in
// a scoreboard, then compared field by field. The bench sends directed
// headers, then shuffled in-order runs mixed with corrupt, repeated and
// far-ahead headers, and ends with a closing packet and dropped headers.
// ----------------------------------------------------------------------------
module tb_cumulative_ack_receiver_unit;

    import cack_pkg::*;

    localparam int SEQ_SPACE    = SEQ_SPACE_DEF;
    localparam int ITEMS_TOTAL  = 1800;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 2 * SEQ_SPACE + 64;

    localparam logic [MODE_W-1:0] FLAG_SYN = 4'b0001 << MODE_SYN_BIT;
    localparam logic [MODE_W-1:0] FLAG_ACK = 4'b0010;
    localparam logic [MODE_W-1:0] FLAG_FIN = 4'b0001 << MODE_FIN_BIT;
    localparam logic [MODE_W-1:0] FLAG_REQ = 4'b1000;

    class ack_scoreboard;
        bit      seq_seen [SEQ_SPACE];
        int      next_seq;
        bit      closed;
        result_t replies_due [$];
        int      errors;

        function void take_header(logic [MODE_W-1:0] md, logic [SEQ_W-1:0] sq, logic ok);
            result_t r;
            int      prev;
            bit      is_data;
            if (closed)
                return;
            is_data = md[MODE_SYN_BIT] && !md[MODE_FIN_BIT];
            r = '0;
            if (is_data && ok)
            begin
                prev = next_seq;
                if (sq < SEQ_SPACE)
                begin
                    seq_seen[sq] = 1'b1;
                    r.store_payload = (sq != 0);
                    r.header_packet = (sq == 0);
                end
                while (next_seq < SEQ_SPACE && seq_seen[next_seq])
                    next_seq++;
                r.reply_kind    = REPLY_ACK;
                r.ack_number    = ACK_W'(next_seq - 1);
                r.duplicate_ack = (next_seq == prev);
            end
            else if (is_data)
            begin
                r.reply_kind = REPLY_RESEND;
                r.ack_number = {1'b0, sq};
            end
            else
            begin
                r.reply_kind = REPLY_FIN;
                closed = 1'b1;
            end
            replies_due.push_back(r);
        endfunction

        function void report(string field, logic [ACK_W-1:0] want, logic [ACK_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_reply(logic [M_TDATA_W-1:0] data, logic [1:0] kind);
            result_t want;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none, actual kind %0h data %0h",
                         $time, kind, data);
                return;
            end
            want = replies_due.pop_front();
            report("reply_kind", ACK_W'(want.reply_kind), ACK_W'(kind));
            report("ack_number", want.ack_number, data[ACK_W-1:0]);
            report("duplicate_ack", ACK_W'(want.duplicate_ack), ACK_W'(data[ACK_W]));
            report("store_payload", ACK_W'(want.store_payload), ACK_W'(data[ACK_W+1]));
            report("header_packet", ACK_W'(want.header_packet), ACK_W'(data[ACK_W+2]));
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [MODE_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;

    ack_scoreboard board = new;
    bit            burst;
    bit            hold_sink;
    int            headers_sent;

    cumulative_ack_receiver_unit #(.SEQ_SPACE(SEQ_SPACE)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.take_header(s_tuser, s_tdata[SEQ_W-1:0], s_tdata[SEQ_W]);
        if (rst_n && m_tvalid && m_tready)
            board.check_reply(m_tdata, m_tuser);
    end

    function automatic int pick_gap();
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [MODE_W-1:0] data_mode();
        logic [MODE_W-1:0] md;
        md = MODE_W'($urandom_range(0, 15));
        md[MODE_SYN_BIT] = 1'b1;
        md[MODE_FIN_BIT] = 1'b0;
        return md;
    endfunction

    task automatic send_header(input logic [MODE_W-1:0] md, input logic [SEQ_W-1:0] sq,
                               input logic ok);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {{(S_TDATA_W-SEQ_W-1){1'b0}}, ok, sq};
        do @(posedge clk); while (s_tready !== 1'b1);
        headers_sent++;
    endtask

    // shuffle a block of consecutive sequence numbers; corrupt some copies first
    task automatic send_run(input int first, input int len);
        int order [16];
        int j;
        int tmp;
        for (int i = 0; i < len; i++)
            order[i] = first + i;
        for (int i = len - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_header(data_mode(), SEQ_W'(order[i]), 1'b0);
            send_header(data_mode(), SEQ_W'(order[i]), 1'b1);
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int stall;
        forever
        begin
            if (hold_sink)
            begin
                hold_sink = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    initial
    begin
        #100_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int                front;
        int                len;
        bit                pressured;
        logic [MODE_W-1:0] md;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_header(FLAG_SYN, 16'd5, 1'b1);
        send_header(FLAG_SYN | FLAG_REQ, 16'hFFFF, 1'b0);
        send_header(FLAG_SYN | FLAG_ACK, 16'd0, 1'b1);
        send_header(FLAG_SYN | FLAG_ACK | FLAG_REQ, 16'd3, 1'b1);
        send_header(FLAG_SYN, 16'd2, 1'b1);
        send_header(FLAG_SYN | FLAG_REQ, 16'd4, 1'b0);
        send_header(FLAG_SYN, 16'd4, 1'b1);
        send_header(FLAG_SYN | FLAG_ACK, 16'd1, 1'b1);
        send_header(FLAG_SYN, 16'd2, 1'b1);
        send_header(FLAG_SYN | FLAG_REQ, 16'd0, 1'b1);
        send_header(FLAG_SYN, SEQ_W'(SEQ_SPACE - 1), 1'b1);
        send_header(FLAG_SYN | FLAG_ACK | FLAG_REQ, 16'hFFFF, 1'b1);
        send_header(FLAG_SYN, 16'h8000, 1'b1);
        send_header(FLAG_SYN | FLAG_ACK, 16'd0, 1'b0);
        send_header(FLAG_SYN, 16'hAAAA, 1'b0);
        send_header(FLAG_SYN | FLAG_REQ, 16'h5555, 1'b0);
        drain_replies();

        front = 6;
        while (headers_sent < ITEMS_TOTAL)
        begin
            burst = ($urandom_range(0, 3) == 0);
            if (!pressured && headers_sent > 700)
            begin
                // fill the block while the receiver holds off, then let it drain
                pressured = 1'b1;
                hold_sink = 1'b1;
                burst = 1'b1;
                send_run(front, 12);
                front += 12;
                drain_replies();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    len = $urandom_range(1, 16);
                    send_run(front, len);
                    front += len;
                end
                7:
                    send_header(data_mode(),
                                SEQ_W'($urandom_range(0, 1) ? $urandom_range(0, front)
                                                            : $urandom_range(0, 65535)),
                                1'b1);
                8:
                    send_header(data_mode(), SEQ_W'($urandom_range(0, 65535)), 1'b0);
                default:
                    send_header(data_mode(), SEQ_W'(front + $urandom_range(1, 40)), 1'b1);
            endcase
        end

        burst = 1'b0;
        md = MODE_W'($urandom_range(0, 15));
        if (md[MODE_SYN_BIT] && !md[MODE_FIN_BIT])
            md[MODE_FIN_BIT] = 1'b1;
        send_header(md, SEQ_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(4, 8))
            send_header(MODE_W'($urandom_range(0, 15)), SEQ_W'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)));
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
